// ===== hdl/fwtt_pkg.sv =====
`timescale 1ns / 1ps

package fwtt_pkg;

  localparam int WAYS       = 4;
  localparam int WAY_BITS   = 2;
  localparam int TAG_BITS   = 26;
  localparam int TAG_LSB    = 32;
  localparam int PRIO_BITS  = 11;
  localparam int MAX_DEPTH  = 63;

  localparam logic signed [16:0] MATE_LEVEL = 17'sd5000;
  localparam logic signed [PRIO_BITS-1:0] NO_REPLACE = 11'sd1000;
  localparam logic signed [PRIO_BITS-1:0] EXACT_BONUS = 11'sd2;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  localparam logic [1:0] CFG_CURRENT_AGE    = 2'd0;
  localparam logic [1:0] CFG_NO_LOWER_BOUND = 2'd1;
  localparam logic [1:0] CFG_NO_UPPER_BOUND = 2'd2;

  localparam logic signed [15:0] RESET_NO_LOWER = -16'sd32000;
  localparam logic signed [15:0] RESET_NO_UPPER = 16'sd32000;

  typedef struct packed {
    logic [1:0]         age;
    logic [5:0]         to_sq;
    logic [1:0]         kind;
    logic [5:0]         from_sq;
    logic signed [15:0] score;
    logic [5:0]         depth;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // distance in generations from an entry's age to the current one
  function automatic logic [1:0] age_gap(input logic [1:0] cur, input logic [1:0] age);
    return cur - age;
  endfunction

endpackage

// ===== hdl/four_way_transposition_table.sv =====
`timescale 1ns / 1ps

// A lookup or store reads and checks one way at a time (S_READ, then S_CHECK)
// until a tag matches or all ways are read; a store miss then writes the victim
// in S_WRITE; a delete clears all four ways in S_WIPE. One transaction at a time;
// S_DONE registers the result, holding while the last one waits for out_ready.
// Reset: synchronous; a pass over all (4 << SET_INDEX_BITS) entries zeroes
// the table, during which no transaction is accepted. Registers reset at once.
module four_way_transposition_table #(
  parameter int SET_INDEX_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [63:0]        position_key,
  input  logic [7:0]         search_depth,
  input  logic [7:0]         ply_distance,
  input  logic signed [15:0] alpha_in,
  input  logic signed [15:0] beta_in,
  input  logic signed [15:0] score_in,
  input  logic [5:0]         from_square,
  input  logic [5:0]         to_square,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [5:0]         entry_depth,
  output logic [1:0]         bound_kind,
  output logic signed [15:0] entry_score,
  output logic [5:0]         best_from,
  output logic [5:0]         best_to,
  output logic signed [15:0] alpha_out,
  output logic signed [15:0] beta_out
);
  import fwtt_pkg::*;

  localparam int ADDR_BITS = SET_INDEX_BITS + WAY_BITS;
  localparam int ENTRIES   = WAYS << SET_INDEX_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_WIPE, S_DONE
  } state_t;

  state_t state;

  entry_t mem [ENTRIES];
  entry_t rd_data;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  entry_t               mem_wdata;
  logic [ADDR_BITS-1:0] rd_addr;

  logic [1:0]         current_age;
  logic signed [15:0] no_lower_bound;
  logic signed [15:0] no_upper_bound;

  logic [ADDR_BITS-1:0]      clr_addr;
  logic [WAY_BITS-1:0]       way;
  logic [WAY_BITS-1:0]       victim;
  logic signed [PRIO_BITS-1:0] best_prio;
  logic [SET_INDEX_BITS-1:0] set_q;
  logic [TAG_BITS-1:0]       tag_q;
  logic [1:0]                req_q;
  logic [7:0]                sdepth_q;
  logic [7:0]                ply_q;
  logic [5:0]                st_depth;
  logic signed [15:0]        st_score;
  logic [1:0]                st_kind;
  logic [5:0]                from_q;
  logic [5:0]                to_q;

  logic               r_hit;
  logic [5:0]         r_depth;
  logic [1:0]         r_kind;
  logic signed [15:0] r_score;
  logic [5:0]         r_from;
  logic [5:0]         r_to;
  logic signed [15:0] r_alpha;
  logic signed [15:0] r_beta;

  // store preparation from the incoming transaction
  logic signed [16:0] in_s17;
  logic signed [16:0] in_ply17;
  logic               in_mate;
  logic signed [15:0] in_adj;
  logic [1:0]         in_kind;
  logic [5:0]         in_depth;

  // lookup and replacement evaluation of the way just read
  logic                      tag_match;
  logic signed [16:0]        lk_s17;
  logic signed [16:0]        ply17;
  logic                      lk_mate;
  logic signed [15:0]        lk_adj;
  logic signed [PRIO_BITS-1:0] prio;
  logic                      last_way;
  entry_t                    new_entry;
  logic                      keep_move;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    in_s17   = {score_in[15], score_in};
    in_ply17 = $signed({9'b0, ply_distance});
    in_mate  = (in_s17 >= MATE_LEVEL) || (in_s17 <= -MATE_LEVEL);
    in_adj   = score_in;
    if (in_mate) begin
      in_adj = sat16((in_s17 > 17'sd0) ? in_s17 + in_ply17 : in_s17 - in_ply17);
    end
    if (score_in < beta_in) begin
      in_kind = (score_in > alpha_in) ? BOUND_EXACT : BOUND_UPPER;
    end else begin
      in_kind = BOUND_LOWER;
    end
    in_depth = (search_depth > 8'(MAX_DEPTH)) ? 6'(MAX_DEPTH) : search_depth[5:0];
  end

  always_comb begin
    tag_match = (rd_data.tag == tag_q);
    lk_s17    = {rd_data.score[15], rd_data.score};
    ply17     = $signed({9'b0, ply_q});
    lk_mate   = (lk_s17 >= MATE_LEVEL) || (lk_s17 <= -MATE_LEVEL);
    lk_adj    = rd_data.score;
    if (lk_mate) begin
      lk_adj = sat16((lk_s17 < 17'sd0) ? lk_s17 + ply17 : lk_s17 - ply17);
    end
    prio = $signed({5'b0, rd_data.depth})
         - $signed({1'b0, age_gap(current_age, rd_data.age), 8'b0})
         + ((rd_data.kind == BOUND_EXACT) ? EXACT_BONUS : '0);
    last_way = (way == WAY_BITS'(WAYS - 1));
    keep_move = (from_q == '0) && (to_q == '0);
    new_entry.age     = current_age;
    new_entry.to_sq   = to_q;
    new_entry.kind    = st_kind;
    new_entry.from_sq = from_q;
    new_entry.score   = st_score;
    new_entry.depth   = st_depth;
    new_entry.tag     = tag_q;
  end

  assign rd_addr = {set_q, way};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_CHECK: begin
        if (req_q == REQ_STORE && tag_match) begin
          mem_we    = 1'b1;
          mem_wdata = new_entry;
          if (keep_move) begin
            mem_wdata.from_sq = rd_data.from_sq;
            mem_wdata.to_sq   = rd_data.to_sq;
          end
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {set_q, victim};
        mem_wdata = new_entry;
      end
      S_WIPE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_age    <= '0;
      no_lower_bound <= RESET_NO_LOWER;
      no_upper_bound <= RESET_NO_UPPER;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CURRENT_AGE:    current_age    <= cfg_data[1:0];
        CFG_NO_LOWER_BOUND: no_lower_bound <= cfg_data;
        CFG_NO_UPPER_BOUND: no_upper_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      way       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_q     <= req_type;
            set_q     <= position_key[SET_INDEX_BITS-1:0];
            tag_q     <= position_key[TAG_LSB +: TAG_BITS];
            sdepth_q  <= search_depth;
            ply_q     <= ply_distance;
            st_depth  <= in_depth;
            st_score  <= in_adj;
            st_kind   <= in_kind;
            from_q    <= from_square;
            to_q      <= to_square;
            way       <= '0;
            victim    <= '0;
            best_prio <= NO_REPLACE;
            r_hit     <= 1'b0;
            r_depth   <= '0;
            r_kind    <= '0;
            r_score   <= '0;
            r_from    <= '0;
            r_to      <= '0;
            r_alpha   <= '0;
            r_beta    <= '0;
            case (req_type)
              REQ_LOOKUP: state <= S_READ;
              REQ_STORE:  state <= S_READ;
              REQ_DELETE: state <= S_WIPE;
              default:    state <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (tag_match) begin
            r_hit <= 1'b1;
            state <= S_DONE;
            if (req_q == REQ_LOOKUP) begin
              r_depth <= rd_data.depth;
              r_kind  <= rd_data.kind;
              r_score <= rd_data.score;
              r_from  <= rd_data.from_sq;
              r_to    <= rd_data.to_sq;
              r_alpha <= no_lower_bound;
              r_beta  <= no_upper_bound;
              if (sdepth_q <= {2'b0, rd_data.depth}) begin
                if (rd_data.kind == BOUND_EXACT) begin
                  r_alpha <= lk_adj;
                  r_beta  <= lk_adj;
                end else if (rd_data.kind == BOUND_LOWER) begin
                  r_alpha <= lk_adj;
                end else begin
                  r_beta <= lk_adj;
                end
              end
            end
          end else begin
            if (prio < best_prio) begin
              best_prio <= prio;
              victim    <= way;
            end
            if (last_way) begin
              state <= (req_q == REQ_STORE) ? S_WRITE : S_DONE;
            end else begin
              way   <= way + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_WIPE: begin
          way <= way + 1'b1;
          if (last_way) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            hit         <= r_hit;
            entry_depth <= r_depth;
            bound_kind  <= r_kind;
            entry_score <= r_score;
            best_from   <= r_from;
            best_to     <= r_to;
            alpha_out   <= r_alpha;
            beta_out    <= r_beta;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/fwtt_checker.sv =====
`timescale 1ns / 1ps

module fwtt_checker #(
  parameter int SET_INDEX_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [63:0]        position_key,
  input  logic [7:0]         search_depth,
  input  logic [7:0]         ply_distance,
  input  logic signed [15:0] alpha_in,
  input  logic signed [15:0] beta_in,
  input  logic signed [15:0] score_in,
  input  logic [5:0]         from_square,
  input  logic [5:0]         to_square,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               hit,
  input  logic [5:0]         entry_depth,
  input  logic [1:0]         bound_kind,
  input  logic signed [15:0] entry_score,
  input  logic [5:0]         best_from,
  input  logic [5:0]         best_to,
  input  logic signed [15:0] alpha_out,
  input  logic signed [15:0] beta_out,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 hit_count
);
  import fwtt_pkg::*;

  localparam int ENTRIES = WAYS << SET_INDEX_BITS;

  typedef struct packed {
    logic               hit;
    logic [5:0]         depth;
    logic [1:0]         kind;
    logic signed [15:0] score;
    logic [5:0]         from_sq;
    logic [5:0]         to_sq;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } tt_reply_t;

  entry_t             slot_mem [ENTRIES];
  logic [1:0]         age_now;
  logic signed [15:0] floor_bound;
  logic signed [15:0] ceil_bound;
  tt_reply_t          reply_q [$];

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Predict the reply to one request and apply its effect on the table copy.
  function automatic tt_reply_t resolve_request(
    input logic [1:0]         req,
    input logic [63:0]        key,
    input logic [7:0]         sdepth,
    input logic [7:0]         ply,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi,
    input logic signed [15:0] score,
    input logic [5:0]         from_sq,
    input logic [5:0]         to_sq
  );
    tt_reply_t           r;
    entry_t              e;
    int                  base;
    int                  pl;
    int                  s;
    int                  prio;
    int                  best;
    int                  victim;
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          gap;
    logic [1:0]          store_kind;
    logic [5:0]          store_depth;
    logic signed [15:0]  store_score;
    logic [5:0]          keep_from;
    logic [5:0]          keep_to;
    r = '0;
    base = int'(key[SET_INDEX_BITS-1:0]) * WAYS;
    tag = key[TAG_LSB +: TAG_BITS];
    pl = int'(ply);
    case (req)
      REQ_LOOKUP: begin
        for (int w = 0; w < WAYS; w++) begin
          e = slot_mem[base + w];
          if (!r.hit && e.tag == tag) begin
            r.hit = 1'b1;
            r.depth = e.depth;
            r.kind = e.kind;
            r.score = e.score;
            r.from_sq = e.from_sq;
            r.to_sq = e.to_sq;
            r.alpha = floor_bound;
            r.beta = ceil_bound;
            if (sdepth <= {2'b00, e.depth}) begin
              s = $signed(e.score);
              // mate scores pull toward zero by the distance from the root
              if (s >= MATE_LEVEL || s <= -MATE_LEVEL) begin
                s = (s < 0) ? s + pl : s - pl;
              end
              case (e.kind)
                BOUND_EXACT: begin
                  r.alpha = clamp16(s);
                  r.beta = clamp16(s);
                end
                BOUND_LOWER: r.alpha = clamp16(s);
                default: r.beta = clamp16(s);
              endcase
            end
          end
        end
      end
      REQ_STORE: begin
        s = $signed(score);
        if (s >= MATE_LEVEL || s <= -MATE_LEVEL) begin
          s = (s > 0) ? s + pl : s - pl;
        end
        store_score = clamp16(s);
        if (score < hi) begin
          store_kind = (score > lo) ? BOUND_EXACT : BOUND_UPPER;
        end else begin
          store_kind = BOUND_LOWER;
        end
        store_depth = (sdepth > MAX_DEPTH) ? 6'(MAX_DEPTH) : sdepth[5:0];
        best = NO_REPLACE;
        victim = 0;
        for (int w = 0; w < WAYS; w++) begin
          e = slot_mem[base + w];
          if (!r.hit) begin
            if (e.tag == tag) begin
              r.hit = 1'b1;
              keep_from = e.from_sq;
              keep_to = e.to_sq;
              if (from_sq != 0 || to_sq != 0) begin
                keep_from = from_sq;
                keep_to = to_sq;
              end
              slot_mem[base + w] = '{age: age_now, to_sq: keep_to, kind: store_kind,
                                     from_sq: keep_from, score: store_score,
                                     depth: store_depth, tag: tag};
            end else begin
              gap = age_now - e.age;
              prio = int'(e.depth) - 256 * int'(gap) + ((e.kind == BOUND_EXACT) ? 2 : 0);
              if (prio < best) begin
                best = prio;
                victim = w;
              end
            end
          end
        end
        if (!r.hit) begin
          slot_mem[base + victim] = '{age: age_now, to_sq: to_sq, kind: store_kind,
                                      from_sq: from_sq, score: store_score,
                                      depth: store_depth, tag: tag};
        end
      end
      REQ_DELETE: begin
        for (int w = 0; w < WAYS; w++) slot_mem[base + w] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    tt_reply_t got;
    tt_reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_mem[i] = '0;
      age_now = '0;
      floor_bound = RESET_NO_LOWER;
      ceil_bound = RESET_NO_UPPER;
      reply_q.delete();
      fail_count = 0;
      result_count = 0;
      hit_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CURRENT_AGE:    age_now = cfg_data[1:0];
          CFG_NO_LOWER_BOUND: floor_bound = cfg_data;
          CFG_NO_UPPER_BOUND: ceil_bound = cfg_data;
          default: ;
        endcase
      end
      // retire the output transaction before queueing a new one
      if (out_valid && out_ready) begin
        got = '{hit, entry_depth, bound_kind, entry_score, best_from, best_to,
                alpha_out, beta_out};
        result_count++;
        if (got.hit) hit_count++;
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result with no request outstanding", $time);
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: expected hit=%0b depth=%0d kind=%0d score=%0d move=%0d-%0d",
                       $time, want.hit, want.depth, want.kind, want.score,
                       want.from_sq, want.to_sq, " alpha=%0d beta=%0d",
                       want.alpha, want.beta);
              $display("%0t: actual   hit=%0b depth=%0d kind=%0d score=%0d move=%0d-%0d",
                       $time, got.hit, got.depth, got.kind, got.score,
                       got.from_sq, got.to_sq, " alpha=%0d beta=%0d",
                       got.alpha, got.beta);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        reply_q.push_back(resolve_request(req_type, position_key, search_depth,
                                          ply_distance, alpha_in, beta_in, score_in,
                                          from_square, to_square));
      end
    end
    pending_count = reply_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fwtt_pkg::*;

  localparam int SET_BITS     = 10;
  localparam int LIMIT        = 20000;
  localparam int HOLD_OFF     = 300;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 147;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         req;
    logic [63:0]        key;
    logic [7:0]         sdepth;
    logic [7:0]         ply;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] score;
    logic [5:0]         from_sq;
    logic [5:0]         to_sq;
  } tt_request_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         req_type;
  logic [63:0]        position_key;
  logic [7:0]         search_depth;
  logic [7:0]         ply_distance;
  logic signed [15:0] alpha_in;
  logic signed [15:0] beta_in;
  logic signed [15:0] score_in;
  logic [5:0]         from_square;
  logic [5:0]         to_square;
  logic               out_valid;
  logic               out_ready;
  logic               hit;
  logic [5:0]         entry_depth;
  logic [1:0]         bound_kind;
  logic signed [15:0] entry_score;
  logic [5:0]         best_from;
  logic [5:0]         best_to;
  logic signed [15:0] alpha_out;
  logic signed [15:0] beta_out;

  int fail_count;
  int pending_count;
  int result_count;
  int hit_count;
  int quiet_cycles;
  int lookups;
  int stores;
  int deletes;
  int ignored;
  bit quiet;
  bit hold_off_req;
  bit hold_off_done;
  bit send_window;
  bit recv_window;

  logic [SET_BITS-1:0] set_pool [8];
  logic [TAG_BITS-1:0] tag_pool [6];

  four_way_transposition_table #(.SET_INDEX_BITS(SET_BITS)) dut (.*);

  fwtt_checker #(.SET_INDEX_BITS(SET_BITS)) u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic tt_request_t req_of(
    input logic [1:0] req, input logic [63:0] key, input logic [7:0] sdepth,
    input logic [7:0] ply, input logic signed [15:0] lo, input logic signed [15:0] hi,
    input logic signed [15:0] score, input logic [5:0] from_sq, input logic [5:0] to_sq
  );
    tt_request_t t;
    t = '{req, key, sdepth, ply, lo, hi, score, from_sq, to_sq};
    return t;
  endfunction

  // random filler in the bits that select neither set nor tag
  function automatic logic [63:0] key_of(input logic [SET_BITS-1:0] set_idx,
                                         input logic [TAG_BITS-1:0] tag);
    logic [63:0] k;
    k = {$urandom, $urandom};
    k[SET_BITS-1:0] = set_idx;
    k[TAG_LSB +: TAG_BITS] = tag;
    return k;
  endfunction

  function automatic tt_request_t random_request();
    tt_request_t t;
    int          pick;
    pick = $urandom_range(0, 99);
    t.key = {$urandom, $urandom};
    t.sdepth = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 70));
    t.ply = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    case ($urandom_range(0, 4))
      0: t.score = 16'($urandom);
      1: t.score = 16'($urandom_range(5000, 32767));
      2: t.score = 16'(-5000 - int'($urandom_range(0, 27768)));
      3: t.score = 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4990, 5010)));
      default: t.score = 16'(int'($urandom_range(0, 1000)) - 500);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        t.lo = 16'($urandom);
        t.hi = 16'($urandom);
      end
      1: begin
        t.lo = t.score - 16'($urandom_range(1, 300));
        t.hi = t.score + 16'($urandom_range(1, 300));
      end
      2: begin
        t.lo = t.score - 16'($urandom_range(1, 300));
        t.hi = t.score - 16'($urandom_range(0, 200));
      end
      default: begin
        t.lo = t.score + 16'($urandom_range(0, 200));
        t.hi = t.score + 16'($urandom_range(201, 400));
      end
    endcase
    if ($urandom_range(0, 4) == 0) begin
      t.from_sq = '0;
      t.to_sq = '0;
    end else begin
      t.from_sq = 6'($urandom);
      t.to_sq = 6'($urandom);
    end
    if (pick < 8) begin
      t.req = 2'($urandom);
    end else begin
      t.key[SET_BITS-1:0] = set_pool[$urandom_range(0, 7)];
      t.key[TAG_LSB +: TAG_BITS] = tag_pool[$urandom_range(0, 5)];
      if (pick < 50) t.req = REQ_LOOKUP;
      else if (pick < 92) t.req = REQ_STORE;
      else if (pick < 97) t.req = REQ_DELETE;
      else t.req = REQ_UNUSED;
    end
    return t;
  endfunction

  task automatic send(input tt_request_t t);
    if (!quiet && send_window && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_type = t.req;
    position_key = t.key;
    search_depth = t.sdepth;
    ply_distance = t.ply;
    alpha_in = t.lo;
    beta_in = t.hi;
    score_in = t.score;
    from_square = t.from_sq;
    to_square = t.to_sq;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    case (t.req)
      REQ_LOOKUP: lookups++;
      REQ_STORE:  stores++;
      REQ_DELETE: deletes++;
      default:    ignored++;
    endcase
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) recv_window = !recv_window;
      if (hold_off_req && !hold_off_done) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_off_done = 1'b1;
      end else if (!quiet && recv_window && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    tt_request_t     t;
    int              sent;
    logic [63:0]     ones;
    logic [1:0]      unused_req;
    cfg_write = 1'b0;
    cfg_index = CFG_CURRENT_AGE;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    req_type = REQ_LOOKUP;
    position_key = '0;
    search_depth = '0;
    ply_distance = '0;
    alpha_in = '0;
    beta_in = '0;
    score_in = '0;
    from_square = '0;
    to_square = '0;
    set_pool[0] = '0;
    set_pool[1] = '1;
    for (int i = 2; i < 8; i++) set_pool[i] = SET_BITS'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = TAG_BITS'($urandom);
    ones = '1;
    unused_req = REQ_UNUSED;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty ways hold tag zero
    send(req_of(REQ_LOOKUP, key_of(5, 0), 0, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_LOOKUP, key_of(5, 1), 0, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_STORE, key_of(5, 1), 200, 255, -32768, 32767, 32767, 63, 63));
    send(req_of(REQ_LOOKUP, key_of(5, 1), 0, 255, 0, 0, 0, 0, 0));
    // zero move keeps the stored one
    send(req_of(REQ_STORE, key_of(5, 1), 5, 10, 0, 100, -32768, 0, 0));
    send(req_of(REQ_LOOKUP, key_of(5, 1), 6, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_LOOKUP, key_of(5, 1), 5, 255, 0, 0, 0, 0, 0));
    send(req_of(REQ_STORE, key_of(5, 2), 0, 255, -1, 5000, 4999, 1, 2));
    send(req_of(REQ_LOOKUP, key_of(5, 2), 0, 255, 0, 0, 0, 0, 0));
    send(req_of(REQ_STORE, key_of(5, 3), 63, 3, -32768, 0, -5000, 12, 28));
    send(req_of(REQ_LOOKUP, key_of(5, 3), 63, 7, 0, 0, 0, 0, 0));
    send(req_of(REQ_STORE, key_of(5, 4), 64, 0, 10, 10, 10, 5, 6));
    // set full: replace the weakest way
    send(req_of(REQ_STORE, key_of(5, 5), 1, 0, -100, 100, 0, 33, 44));
    send(req_of(REQ_LOOKUP, key_of(5, 0), 0, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_DELETE, key_of(5, 3), 0, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_LOOKUP, key_of(5, 1), 0, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_LOOKUP, key_of(5, 0), 0, 0, 0, 0, 0, 0, 0));
    send(req_of(unused_req, key_of(5, 0), 7, 9, -5, 5, 123, 3, 4));
    send(req_of(REQ_STORE, key_of(5, 0), 3, 0, 0, 1000, 100, 7, 9));
    send(req_of(REQ_LOOKUP, ones, 0, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_STORE, ones, 0, 0, 0, 32767, 5000, 0, 0));
    send(req_of(REQ_LOOKUP, ones, 255, 0, 0, 0, 0, 0, 0));
    send(req_of(REQ_LOOKUP, ones, 0, 255, 0, 0, 0, 0, 0));

    for (int ph = 1; ph <= PHASES; ph++) begin
      drain();
      write_reg(CFG_CURRENT_AGE, 16'(ph % 4));
      case (ph)
        1: begin
          write_reg(CFG_NO_LOWER_BOUND, 16'sh8000);
          write_reg(CFG_NO_UPPER_BOUND, 16'sh7FFF);
        end
        2: begin
          write_reg(CFG_NO_LOWER_BOUND, 16'sh7FFF);
          write_reg(CFG_NO_UPPER_BOUND, 16'sh8000);
          hold_off_req = 1'b1;
        end
        default: begin
          write_reg(CFG_NO_LOWER_BOUND, 16'($urandom));
          write_reg(CFG_NO_UPPER_BOUND, 16'($urandom));
        end
      endcase
      if (ph == PHASES) quiet = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) send_window = !send_window;
        t = random_request();
        send(t);
        if (t.req != REQ_UNUSED) sent++;
      end
    end

    drain();
    $display("Run covered %0d lookups, %0d stores, %0d set deletes, %0d unused requests",
             lookups, stores, deletes, ignored);
    $display("across all four ages and extreme bounds; %0d results, %0d tag hits, %0d bad",
             result_count, hit_count, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fwtt_pkg.sv
hdl/four_way_transposition_table.sv
dv/fwtt_checker.sv
dv/tb_top.sv
